/* rtl/nswf_pkg.sv */
// ----------------------------------------------------------------------------
// nswf_pkg
// Shared types and constants of the normalized symmetric window filter.
// ----------------------------------------------------------------------------
package nswf_pkg;

    localparam int FW_BITS       = 11;
    localparam int FH_BITS       = 16;
    localparam int REACH_BITS    = 3;
    localparam int COEF_ROW_BITS = 64;
    localparam int COEF_LANES    = 4;
    localparam int LANE_BITS     = 16;
    localparam int PIXEL_BITS    = 16;
    localparam int APB_DATA_BITS = 64;
    localparam int APB_ADDR_BITS = 6;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_QUAD_ROWS    = 3'd2,
        REG_QUAD_COLS    = 3'd3,
        REG_COEF_ROW0    = 3'd4,
        REG_COEF_ROW1    = 3'd5,
        REG_COEF_ROW2    = 3'd6,
        REG_COEF_ROW3    = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TAPS,
        S_FLUSH,
        S_DIV_GO,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

endpackage

/* rtl/normalized_symmetric_window_filter.sv */
// ----------------------------------------------------------------------------
// normalized_symmetric_window_filter
// Raster-stream normalized window filter with mirror-symmetric weights and
// edge truncation; line rows kept in one RAM.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  input   | i_in_valid / o_in_stall    | i_kind, i_pixel
//  output  | o_out_valid / i_out_stall  | o_out_pixel, o_zero_weight, o_frame_last
//  config  | psel penable pwrite pready | paddr, pwdata, prdata (64-bit regs at 8*i)
//
//  One word at a time: a word that yields nothing returns to idle after the check;
//  otherwise taps are read in turn, products flushed, the sum divided (skipped for
//  a zero weight sum) and the result emitted; taps share the one RAM port.
//  Synchronous active-low reset clears counters and loads register defaults;
//  line RAM is not cleared. Input stall is high outside idle; a result waits
//  in the output register, and a second one holds the block until it drains.
// ----------------------------------------------------------------------------
module normalized_symmetric_window_filter #(
    parameter int MAX_WIDTH   = 1024,
    parameter int QUAD_SIZE   = 4,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_kind,
    input  logic signed [nswf_pkg::PIXEL_BITS-1:0] i_pixel,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [nswf_pkg::PIXEL_BITS-1:0] o_out_pixel,
    output logic                                 o_zero_weight,
    output logic                                 o_frame_last,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [nswf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [nswf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [nswf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import nswf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SR    = 2 * QUAD_SIZE;
    localparam int SLW   = $clog2(SR);
    localparam int DW    = $clog2(QUAD_SIZE) + 1;
    localparam int RW    = $clog2(QUAD_SIZE + 1);
    localparam int AW    = $clog2(SR * MAX_WIDTH);
    localparam int LG    = $clog2(SR);
    localparam int ACCW  = SAMPLE_BITS + COEF_BITS + 2 * LG;
    localparam int WSW   = COEF_BITS + 2 * LG + 1;
    localparam int PW    = SAMPLE_BITS + COEF_BITS;
    localparam int RRW   = FH_BITS + 2;
    localparam int CCW   = CW + 2;
    localparam int XW    = (SAMPLE_BITS > PIXEL_BITS) ? SAMPLE_BITS : PIXEL_BITS;

    // configuration
    logic [FW_BITS-1:0]       r_frame_width;
    logic [FH_BITS-1:0]       r_frame_height;
    logic [REACH_BITS-1:0]    r_quad_rows;
    logic [REACH_BITS-1:0]    r_quad_cols;
    logic [COEF_ROW_BITS-1:0] r_coef [COEF_LANES];
    logic                     cfg_wr;
    t_reg_idx                 cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_ADDR_BITS-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_BITS'(1024);
            r_frame_height <= FH_BITS'(1024);
            r_quad_rows    <= REACH_BITS'(1);
            r_quad_cols    <= REACH_BITS'(1);
            r_coef[0]      <= COEF_ROW_BITS'(1);
            r_coef[1]      <= '0;
            r_coef[2]      <= '0;
            r_coef[3]      <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[FW_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[FH_BITS-1:0];
                REG_QUAD_ROWS:    r_quad_rows    <= pwdata[REACH_BITS-1:0];
                REG_QUAD_COLS:    r_quad_cols    <= pwdata[REACH_BITS-1:0];
                REG_COEF_ROW0:    r_coef[0]      <= pwdata;
                REG_COEF_ROW1:    r_coef[1]      <= pwdata;
                REG_COEF_ROW2:    r_coef[2]      <= pwdata;
                REG_COEF_ROW3:    r_coef[3]      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(r_frame_height);
            REG_QUAD_ROWS:    prdata = APB_DATA_BITS'(r_quad_rows);
            REG_QUAD_COLS:    prdata = APB_DATA_BITS'(r_quad_cols);
            REG_COEF_ROW0:    prdata = r_coef[0];
            REG_COEF_ROW1:    prdata = r_coef[1];
            REG_COEF_ROW2:    prdata = r_coef[2];
            REG_COEF_ROW3:    prdata = r_coef[3];
            default:          prdata = '0;
        endcase
    end

    // effective limits
    logic [WW-1:0]      w;
    logic [FH_BITS-1:0] h;
    logic [RW-1:0]      reach_r;
    logic [RW-1:0]      reach_c;

    always_comb begin
        if (r_frame_width == '0) begin
            w = WW'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(r_frame_width);
        end
        h = (r_frame_height == '0) ? FH_BITS'(1) : r_frame_height;
        if (r_quad_rows == '0) begin
            reach_r = RW'(1);
        end else if (32'(r_quad_rows) > QUAD_SIZE) begin
            reach_r = RW'(QUAD_SIZE);
        end else begin
            reach_r = RW'(r_quad_rows);
        end
        if (r_quad_cols == '0) begin
            reach_c = RW'(1);
        end else if (32'(r_quad_cols) > QUAD_SIZE) begin
            reach_c = RW'(QUAD_SIZE);
        end else begin
            reach_c = RW'(r_quad_cols);
        end
    end

    // state
    t_state r_state, n_state;

    logic [CW-1:0]        r_in_col, r_out_col;
    logic [FH_BITS-1:0]   r_in_row, r_out_row;
    logic [SLW-1:0]       r_in_slot, r_out_slot;
    logic                 r_in_done;
    logic signed [DW-1:0] r_dy, r_dx;
    logic                 r_flush;
    logic                 r_t_v;
    logic signed [COEF_BITS-1:0] r_t_wt;
    logic signed [PW-1:0]   r_prod;
    logic signed [ACCW-1:0] r_acc;
    logic signed [WSW-1:0]  r_ws;
    logic                   r_neg;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                   r_zero;
    logic                   r_ov;
    logic [PIXEL_BITS-1:0]  r_opix;
    logic                   r_oz;
    logic                   r_olast;

    logic in_acc, take_pixel, issue, last_tap, div_start, div_done, emit, out_free;
    logic ready;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign take_pixel = in_acc && (i_kind == KIND_PIXEL) && !r_in_done;
    assign out_free   = !r_ov || !i_out_stall;
    assign last_tap   = (r_dy == DW'(reach_r - 1'b1)) && (r_dx == DW'(reach_c - 1'b1));

    // readiness of the next output position
    logic [FH_BITS:0] tr;
    logic [WW:0]      tc;
    always_comb begin
        tr = {1'b0, r_out_row} + (FH_BITS + 1)'(reach_r) - 1'b1;
        if (tr > {1'b0, h} - 1'b1) begin
            tr = {1'b0, h} - 1'b1;
        end
        tc = (WW + 1)'(r_out_col) + (WW + 1)'(reach_c) - 1'b1;
        if (tc > {1'b0, w} - 1'b1) begin
            tc = {1'b0, w} - 1'b1;
        end
        ready = r_in_done || ({1'b0, r_in_row} > tr) ||
                (({1'b0, r_in_row} == tr) && ((WW + 1)'(r_in_col) > tc));
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        issue      = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = ready ? S_TAPS : S_IDLE;
            end
            S_TAPS: begin
                issue = 1'b1;
                if (last_tap) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_flush) begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                if (r_ws == '0) begin
                    n_state = S_EMIT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // window tap addressing
    logic signed [RRW-1:0]   rr;
    logic signed [CCW-1:0]   cc;
    logic signed [CCW-1:0]   w_s;
    logic                    inb;
    logic [DW-1:0]           ady, adx;
    logic signed [SLW+1:0]   sl;
    logic [SLW-1:0]          tap_slot;
    logic [AW-1:0]           tap_addr, wr_addr;
    logic signed [COEF_BITS-1:0] wt, wt_m;

    always_comb begin
        rr  = $signed({2'b0, r_out_row}) + RRW'(r_dy);
        cc  = $signed({2'b0, r_out_col}) + CCW'(r_dx);
        w_s = $signed(CCW'(w));
        inb = !rr[RRW-1] && (rr < $signed({2'b0, h})) && !cc[CCW-1] && (cc < w_s);
        ady = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
        adx = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
        sl  = $signed({2'b0, r_out_slot}) + (SLW + 2)'(r_dy);
        if (sl < 0) begin
            sl = sl + (SLW + 2)'(SR);
        end else if (sl >= $signed((SLW + 2)'(SR))) begin
            sl = sl - (SLW + 2)'(SR);
        end
        tap_slot = sl[SLW-1:0];
        tap_addr = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(cc[CW-1:0]);
        wr_addr  = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
        // lanes beyond the stored quadrant weigh zero
        wt = '0;
        for (int k = 0; k < COEF_LANES; k++) begin
            for (int j = 0; j < COEF_LANES; j++) begin
                if ((32'(ady) == k) && (32'(adx) == j)) begin
                    wt = $signed(r_coef[k][LANE_BITS*j +: COEF_BITS]);
                end
            end
        end
        wt_m = inb ? wt : '0;
    end

    // line store
    logic [XW-1:0]          px_ext;
    logic [SAMPLE_BITS-1:0] rdata;

    assign px_ext = XW'($unsigned(i_pixel));

    nswf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SR * MAX_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (take_pixel || issue),
        .i_we    (take_pixel),
        .i_addr  (take_pixel ? wr_addr : tap_addr),
        .i_wdata (px_ext[SAMPLE_BITS-1:0]),
        .o_rdata (rdata)
    );

    // divider
    logic [ACCW-1:0] num_mag;
    logic [WSW-1:0]  den_mag;
    logic [ACCW-1:0] quo;

    assign num_mag = r_acc[ACCW-1] ? ACCW'(-r_acc) : ACCW'(r_acc);
    assign den_mag = r_ws[WSW-1] ? WSW'(-r_ws) : WSW'(r_ws);

    nswf_div #(
        .NUM_BITS (ACCW),
        .DEN_BITS (WSW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    localparam logic [ACCW-1:0] LIM = ACCW'((64'd1 << (SAMPLE_BITS - 1)) - 1);

    logic signed [SAMPLE_BITS-1:0] sat;
    always_comb begin
        if (!r_neg) begin
            sat = (quo > LIM) ? $signed(LIM[SAMPLE_BITS-1:0]) : $signed(quo[SAMPLE_BITS-1:0]);
        end else if (quo > LIM + 1'b1) begin
            sat = $signed({1'b1, {(SAMPLE_BITS - 1){1'b0}}});
        end else begin
            sat = -$signed(quo[SAMPLE_BITS-1:0]);
        end
    end

    // position counters, next values
    logic [WW-1:0]    in_col_inc, out_col_inc;
    logic [FH_BITS:0] in_row_inc, out_row_inc;
    assign in_col_inc  = WW'(r_in_col) + 1'b1;
    assign out_col_inc = WW'(r_out_col) + 1'b1;
    assign in_row_inc  = {1'b0, r_in_row} + 1'b1;
    assign out_row_inc = {1'b0, r_out_row} + 1'b1;

    logic signed [XW-1:0] res_ext;
    assign res_ext = XW'(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_in_slot  <= '0;
            r_in_done  <= 1'b0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_out_slot <= '0;
            r_dy       <= '0;
            r_dx       <= '0;
            r_flush    <= 1'b0;
            r_t_v      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (take_pixel) begin
                if (in_col_inc >= w) begin
                    r_in_col <= '0;
                    if (in_row_inc >= {1'b0, h}) begin
                        r_in_row  <= '0;
                        r_in_slot <= '0;
                        r_in_done <= 1'b1;
                    end else begin
                        r_in_row  <= in_row_inc[FH_BITS-1:0];
                        r_in_slot <= (r_in_slot == SLW'(SR - 1)) ? '0 : r_in_slot + 1'b1;
                    end
                end else begin
                    r_in_col <= in_col_inc[CW-1:0];
                end
            end

            if (r_state == S_CHECK) begin
                r_dy <= -DW'(reach_r - 1'b1);
                r_dx <= -DW'(reach_c - 1'b1);
            end else if (issue) begin
                if (r_dx == DW'(reach_c - 1'b1)) begin
                    r_dx <= -DW'(reach_c - 1'b1);
                    r_dy <= r_dy + 1'b1;
                end else begin
                    r_dx <= r_dx + 1'b1;
                end
            end

            r_flush <= (r_state == S_FLUSH) && !r_flush;
            r_t_v   <= issue && inb;

            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (emit) begin
                r_ov <= 1'b1;
                if (out_col_inc >= w) begin
                    r_out_col <= '0;
                    if (out_row_inc >= {1'b0, h}) begin
                        r_out_row  <= '0;
                        r_out_slot <= '0;
                        r_in_done  <= 1'b0;
                    end else begin
                        r_out_row  <= out_row_inc[FH_BITS-1:0];
                        r_out_slot <= (r_out_slot == SLW'(SR - 1)) ? '0 : r_out_slot + 1'b1;
                    end
                end else begin
                    r_out_col <= out_col_inc[CW-1:0];
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_t_wt <= wt_m;
        r_prod <= r_t_v ? PW'(r_t_wt * $signed(rdata)) : '0;
        if (r_state == S_CHECK) begin
            r_acc <= '0;
            r_ws  <= '0;
        end else begin
            r_acc <= r_acc + ACCW'(r_prod);
            if (issue) begin
                r_ws <= r_ws + WSW'(wt_m);
            end
        end
        if (r_state == S_DIV_GO) begin
            r_neg  <= r_acc[ACCW-1] ^ r_ws[WSW-1];
            r_zero <= (r_ws == '0);
            r_res  <= '0;
        end
        if (div_done) begin
            r_res <= sat;
        end
        if (emit) begin
            r_opix  <= res_ext[PIXEL_BITS-1:0];
            r_oz    <= r_zero;
            r_olast <= (out_col_inc >= w) && (out_row_inc >= {1'b0, h});
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_pixel   = $signed(r_opix);
    assign o_zero_weight = r_oz;
    assign o_frame_last  = r_olast;
endmodule

/* rtl/nswf_ram.sv */
// ----------------------------------------------------------------------------
// nswf_ram
// Single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module nswf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/nswf_div.sv */
// ----------------------------------------------------------------------------
// nswf_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nswf_div #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [DEN_BITS:0]   r_rem;
    logic [NUM_BITS-1:0] r_quo;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    assign trial = {r_rem[DEN_BITS-1:0], r_quo[NUM_BITS-1]};
    assign fits  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
                r_quo <= {r_quo[NUM_BITS-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

/* rtl/nswf_chk.sv */
// ----------------------------------------------------------------------------
// nswf_chk
// Port-level checks of the window filter, bound to the top level.
// ----------------------------------------------------------------------------
module nswf_chk (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic signed [nswf_pkg::PIXEL_BITS-1:0] o_out_pixel,
    input logic                                   o_zero_weight,
    input logic                                   o_frame_last
);
    import nswf_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_pixel)
            && $stable(o_zero_weight) && $stable(o_frame_last))
        else $error("stalled output word changed");

    a_zero_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_weight |-> o_out_pixel == '0)
        else $error("zero weight sum with nonzero pixel");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous word in work");
endmodule

bind normalized_symmetric_window_filter nswf_chk u_nswf_chk (.*);

/* sim/normalized_symmetric_window_filter_tb.sv */
// ----------------------------------------------------------------------------
// normalized_symmetric_window_filter_tb
// Self-checking bench: frames of signed pixels go in through the valid/stall
// input port while a behavioral filter model predicts every output word.
// Outputs are compared field by field in order. Registers are loaded over the
// APB-style port between frames. Both sides idle at random, and one phase
// holds the output stalled long enough to back the block up.
// ----------------------------------------------------------------------------
module normalized_symmetric_window_filter_tb;
    import nswf_pkg::*;

    localparam int  MAX_W       = 1024;
    localparam int  STORE_ROWS  = 8;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  ITEM_GOAL   = 1300;
    localparam int  IDLE_WAIT   = 150;

    typedef struct packed {
        logic signed [PIXEL_BITS-1:0] value;
        logic                         zero_w;
        logic                         last;
    } t_filt_word;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic                         i_kind;
    logic signed [PIXEL_BITS-1:0] i_pixel;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [PIXEL_BITS-1:0] o_out_pixel;
    logic                         o_zero_weight;
    logic                         o_frame_last;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [APB_ADDR_BITS-1:0]     paddr;
    logic [APB_DATA_BITS-1:0]     pwdata;
    logic [APB_DATA_BITS-1:0]     prdata;
    logic                         pready;

    normalized_symmetric_window_filter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_kind(i_kind), .i_pixel(i_pixel),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_pixel(o_out_pixel), .o_zero_weight(o_zero_weight),
        .o_frame_last(o_frame_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // filter model state
    logic signed [PIXEL_BITS-1:0] line_mem [STORE_ROWS][MAX_W];
    logic [10:0]  cfg_width;
    logic [15:0]  cfg_height;
    logic [2:0]   cfg_rows;
    logic [2:0]   cfg_cols;
    logic [63:0]  cfg_coef [4];
    int           pix_row, pix_col, res_row, res_col;
    bit           tail_pending;

    t_filt_word   filt_q [$];
    int           mismatches;
    int           words_checked;
    int           pixels_sent;
    int           frames_done;
    int           cycles;
    int           stall_hold;
    bit           tx_idle_on;
    bit           rx_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint weight(int i, int j);
        logic signed [15:0] lane;
        lane = cfg_coef[i][16*j +: 16];
        return longint'(lane);
    endfunction

    // advance the model by one accepted word; returns 1 with a word when one is due
    function automatic bit filt_step(logic kind, logic signed [15:0] pix,
                                     output t_filt_word res);
        int w, h, rr, cc, tr, tc, reach_r, reach_c;
        longint acc, wsum, q;
        bit ready;
        w = (cfg_width < 1) ? 1 : (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
        h = (cfg_height < 1) ? 1 : int'(cfg_height);
        reach_r = (cfg_rows < 1) ? 1 : (cfg_rows > 4) ? 4 : int'(cfg_rows);
        reach_c = (cfg_cols < 1) ? 1 : (cfg_cols > 4) ? 4 : int'(cfg_cols);
        acc = 0;
        wsum = 0;
        q = 0;
        res = '0;
        if (kind == KIND_PIXEL && !tail_pending) begin
            line_mem[pix_row % STORE_ROWS][pix_col] = pix;
            pix_col++;
            if (pix_col >= w) begin
                pix_col = 0;
                pix_row++;
                if (pix_row >= h) begin
                    pix_row = 0;
                    tail_pending = 1'b1;
                end
            end
        end
        tr = (res_row + reach_r - 1 > h - 1) ? h - 1 : res_row + reach_r - 1;
        tc = (res_col + reach_c - 1 > w - 1) ? w - 1 : res_col + reach_c - 1;
        ready = tail_pending || pix_row > tr || (pix_row == tr && pix_col > tc);
        if (!ready) return 1'b0;
        for (int dy = -(reach_r - 1); dy <= reach_r - 1; dy++) begin
            rr = res_row + dy;
            if (rr < 0 || rr >= h) continue;
            for (int dx = -(reach_c - 1); dx <= reach_c - 1; dx++) begin
                cc = res_col + dx;
                if (cc < 0 || cc >= w) continue;
                wsum += weight(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx);
                acc  += weight(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx)
                        * longint'(line_mem[rr % STORE_ROWS][cc]);
            end
        end
        if (wsum != 0) begin
            q = acc / wsum;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
        end
        res.value  = q[15:0];
        res.zero_w = (wsum == 0);
        res_col++;
        if (res_col >= w) begin
            res_col = 0;
            res_row++;
            if (res_row >= h) begin
                res_row = 0;
                res.last = 1'b1;
                tail_pending = 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // receiver stall pattern; a long hold-off is counted down here
    initial begin
        int gap;
        gap = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                stall_hold--;
                i_out_stall = 1'b1;
            end else if (!rx_idle_on) begin
                i_out_stall = 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_out_stall = 1'b1;
            end else begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 6) gap = $urandom_range(10, 40);
                else if (r < 25) gap = $urandom_range(1, 3);
                i_out_stall = (gap > 0);
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_filt_word exp_w;
            if (filt_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word pix=%0d zw=%0b last=%0b",
                             o_out_pixel, o_zero_weight, o_frame_last);
            end else begin
                exp_w = filt_q.pop_front();
                words_checked++;
                if (o_out_pixel !== exp_w.value || o_zero_weight !== exp_w.zero_w ||
                    o_frame_last !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 words_checked, exp_w.value, exp_w.zero_w, exp_w.last,
                                 o_out_pixel, o_zero_weight, o_frame_last);
                end
                if (exp_w.last) frames_done++;
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(logic kind, logic signed [15:0] pix);
        t_filt_word res;
        int gap, r;
        gap = 0;
        if (tx_idle_on) begin
            r = $urandom_range(0, 99);
            if (r < 3) gap = $urandom_range(15, 60);
            else if (r < 25) gap = $urandom_range(1, 3);
        end
        repeat (gap) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_kind     = kind;
        i_pixel    = pix;
        do @(posedge i_clk); while (o_in_stall);
        if (kind == KIND_PIXEL && !tail_pending) pixels_sent++;
        if (filt_step(kind, pix, res)) filt_q.push_back(res);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_pixel    = 16'($urandom);
    endtask

    task automatic apb_write(t_reg_idx idx, logic [63:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_BITS'(idx) << 3;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = value[10:0];
            REG_FRAME_HEIGHT: cfg_height = value[15:0];
            REG_QUAD_ROWS:    cfg_rows   = value[2:0];
            REG_QUAD_COLS:    cfg_cols   = value[2:0];
            default:          cfg_coef[idx - REG_COEF_ROW0] = value;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_idle();
        wait (filt_q.size() == 0);
        repeat (IDLE_WAIT) @(negedge i_clk);
    endtask

    task automatic load_setup(int w, int h, int qr, int qc, logic [63:0] c0,
                              logic [63:0] c1, logic [63:0] c2, logic [63:0] c3);
        wait_idle();
        apb_write(REG_FRAME_WIDTH, 64'(w));
        apb_write(REG_FRAME_HEIGHT, 64'(h));
        apb_write(REG_QUAD_ROWS, 64'(qr));
        apb_write(REG_QUAD_COLS, 64'(qc));
        apb_write(REG_COEF_ROW0, c0);
        apb_write(REG_COEF_ROW1, c1);
        apb_write(REG_COEF_ROW2, c2);
        apb_write(REG_COEF_ROW3, c3);
    endtask

    function automatic logic signed [15:0] pick_pixel(int style);
        int r;
        r = $urandom_range(0, 9);
        if (style == 1 || (style == 2 && r < 3))
            return (r[0]) ? 16'sh7FFF : 16'sh8000;
        if (style == 3) return 16'($urandom_range(0, 200)) - 16'sd100;
        return 16'($urandom);
    endfunction

    // one frame in raster order, optional drain noise, then drained to its end
    task automatic run_frame(int style, int noise_pct);
        int w, h;
        w = (cfg_width < 1) ? 1 : (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
        h = (cfg_height < 1) ? 1 : int'(cfg_height);
        for (int n = 0; n < w * h; n++) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(KIND_DRAIN, 16'($urandom));
            send_word(KIND_PIXEL, pick_pixel(style));
        end
        // stray pixels during the tail are discarded by the block
        while (tail_pending)
            send_word(($urandom_range(0, 3) == 0) ? KIND_PIXEL : KIND_DRAIN, 16'($urandom));
    endtask

    function automatic logic [63:0] rand_coef_row(int style);
        logic [63:0] v;
        for (int j = 0; j < 4; j++) begin
            case (style)
                0:       v[16*j +: 16] = 16'($urandom);
                1:       v[16*j +: 16] = 16'($urandom_range(0, 8));
                default: v[16*j +: 16] = 16'($urandom_range(0, 8)) - 16'd4;
            endcase
        end
        return v;
    endfunction

    task automatic test_passthrough();
        load_setup(5, 3, 1, 1, 64'd1, 64'd0, 64'd0, 64'd0);
        run_frame(2, 0);
    endtask

    task automatic test_max_weights();
        load_setup(4, 4, 4, 4, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
        run_frame(1, 0);
        load_setup(3, 3, 4, 4, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        run_frame(1, 0);
    endtask

    task automatic test_zero_weight_and_saturation();
        load_setup(3, 2, 2, 2, 64'd0, 64'd0, 64'd0, 64'd0);
        run_frame(0, 0);
        // center 2, side -1: interior sums to zero, edges may saturate
        load_setup(4, 1, 1, 2, {32'd0, 16'hFFFF, 16'd2}, 64'd0, 64'd0, 64'd0);
        run_frame(1, 0);
    endtask

    task automatic test_degenerate_regs();
        // zero width and height act as one; out-of-range reaches clamp
        load_setup(0, 65535, 0, 7, 64'd3, 64'd1, 64'd1, 64'd1);
        load_setup(0, 0, 0, 7, 64'd3, 64'd1, 64'd1, 64'd1);
        run_frame(0, 0);
        send_word(KIND_DRAIN, 16'sh7FFF);
        load_setup(2, 1, 7, 0, 64'd5, 64'd2, 64'd1, 64'd1);
        run_frame(0, 0);
    endtask

    task automatic test_backpressure();
        load_setup(6, 5, 2, 3, rand_coef_row(1), rand_coef_row(1), 64'd0, 64'd0);
        wait_idle();
        stall_hold = 600;
        run_frame(0, 0);
    endtask

    task automatic test_wide_frame();
        load_setup(2047, 1, 1, 4, rand_coef_row(1), 64'd0, 64'd0, 64'd0);
        run_frame(0, 2);
    endtask

    task automatic test_random_frames();
        int qr, qc, cs;
        while (pixels_sent < ITEM_GOAL) begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            qr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            qc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            cs = $urandom_range(0, 2);
            load_setup($urandom_range(1, 12), $urandom_range(1, 8), qr, qc,
                       rand_coef_row(cs), rand_coef_row(cs), rand_coef_row(cs),
                       rand_coef_row(cs));
            run_frame($urandom_range(0, 3), ($urandom_range(0, 2) == 0) ? 10 : 0);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_PIXEL;
        i_pixel     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        stall_hold  = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        mismatches  = 0;
        words_checked = 0;
        pixels_sent = 0;
        frames_done = 0;
        cfg_width   = 11'd1024;
        cfg_height  = 16'd1024;
        cfg_rows    = 3'd1;
        cfg_cols    = 3'd1;
        cfg_coef[0] = 64'd1;
        for (int i = 1; i < 4; i++) cfg_coef[i] = '0;
        pix_row = 0; pix_col = 0; res_row = 0; res_col = 0;
        tail_pending = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_passthrough();
        test_max_weights();
        test_zero_weight_and_saturation();
        test_degenerate_regs();
        test_backpressure();
        test_wide_frame();
        test_random_frames();

        wait (filt_q.size() == 0);
        repeat (IDLE_WAIT) @(negedge i_clk);
        $display("Sent %0d pixels in %0d frames, checked %0d output words, %0d mismatches",
                 pixels_sent, frames_done, words_checked, mismatches);
        $display("Covered edge truncation, zero weight sums, saturation, clamped regs, stalls");
        if (mismatches == 0 && filt_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
